[design/jet_pkg.sv]
// shared types, constants and saturation helper for the julia escape-time engine
package jet_pkg;

  localparam int WIDTH_PIX_DEF  = 1024;
  localparam int HEIGHT_PIX_DEF = 1024;
  localparam int MAX_ITER_DEF   = 255;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  // 2.0 in q4.28, held wide for the start point sums
  localparam logic signed [39:0] Q_TWO = 40'sd536870912;

  localparam logic signed [30:0] C_REAL_RST = 31'sd0;
  localparam logic signed [30:0] C_IMAG_RST = -31'sd268435456;
  localparam logic signed [31:0] OFF_RST    = 32'sd0;
  localparam logic        [31:0] ZOOM_RST   = 32'h1000_0000;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } pix_t;

  typedef struct packed {
    logic [9:0] out_pixel_x;
    logic [9:0] out_pixel_y;
    logic [8:0] iter_count;
  } res_t;

  // start point handed from the mapper to the iterator
  typedef struct packed {
    logic [9:0]         pixel_x;
    logic [9:0]         pixel_y;
    logic signed [31:0] z_real;
    logic signed [31:0] z_imag;
  } task_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < 40'shFF80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/jet_fifo.sv]
// small register-based queue used between the pipeline parts
module jet_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

[design/jet_front.sv]
// front end: maps a pixel to its start point with a shared multiplier and reciprocal divider
module jet_front #(
  parameter int WIDTH_PIX  = jet_pkg::WIDTH_PIX_DEF,
  parameter int HEIGHT_PIX = jet_pkg::HEIGHT_PIX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  jet_pkg::pix_t       pix_i,
  input  logic signed [31:0]  off_h_i,
  input  logic signed [31:0]  off_v_i,
  input  logic        [31:0]  zoom_i,
  output jet_pkg::task_t      task_o,
  output logic                task_push_o,
  input  logic                task_full_i
);

  localparam int SizeMax = (WIDTH_PIX > HEIGHT_PIX) ? WIDTH_PIX : HEIGHT_PIX;
  localparam int SW      = $clog2(SizeMax + 1);
  localparam int QW      = 34;
  localparam logic [SW-1:0] SizeX  = SW'(WIDTH_PIX);
  localparam logic [SW-1:0] SizeY  = SW'(HEIGHT_PIX);
  // floor(2^32 / size), fits 32 bits since size is at least two
  localparam logic [31:0]   RecipX = 32'((64'd1 << 32) / 64'(WIDTH_PIX));
  localparam logic [31:0]   RecipY = 32'((64'd1 << 32) / 64'(HEIGHT_PIX));

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL_HI, S_MUL_LO, S_DIV_INIT, S_RECIP, S_REM, S_ADJ, S_FIN, S_PUSH
  } state_e;

  state_e             state_q;
  logic               axis_q;
  jet_pkg::pix_t      pix_q;
  logic               neg_q;
  logic        [31:0] mag_q;
  logic        [63:0] prod_q;
  logic               sat_q;
  logic               step_q;
  logic        [31:0] x_q, qe_q, r_q;
  logic        [13:0] q1_q;
  logic      [QW-1:0] quo_q;
  logic signed [31:0] zr_q, zi_q;

  logic        [9:0]  pos_w;
  logic        [31:0] off_w;
  logic        [33:0] p_w, mag_w;
  logic        [15:0] zsel_w;
  logic        [47:0] mult_w;
  logic      [SW-1:0] size_w;
  logic        [31:0] recip_w;
  logic        [63:0] recip_prod_w;
  logic     [31+SW:0] bprod_w;
  logic               ge_w, big_w;
  logic        [31:0] radj_w, qfix_w;
  logic      [QW:0]   qe_w;
  logic signed [QW+1:0] sq_w;
  logic signed [39:0] coord_w;

  assign pos_w  = axis_q ? pix_q.pixel_y : pix_q.pixel_x;
  assign off_w  = axis_q ? off_v_i : off_h_i;
  // q16.16 pixel position plus offset, two's complement
  assign p_w    = {8'd0, pos_w, 16'd0} + {{2{off_w[31]}}, off_w};
  assign mag_w  = p_w[33] ? (34'd0 - p_w) : p_w;

  assign zsel_w = (state_q == S_MUL_HI) ? zoom_i[31:16] : zoom_i[15:0];
  assign mult_w = mag_q * zsel_w;

  assign size_w  = axis_q ? SizeY : SizeX;
  assign recip_w = axis_q ? RecipY : RecipX;
  // quotient estimate is exact or one low, the remainder step fixes it
  assign recip_prod_w = x_q * recip_w;
  assign bprod_w      = qe_q * size_w;
  assign ge_w         = (r_q >= 32'(size_w));
  assign radj_w       = ge_w ? (r_q - 32'(size_w)) : r_q;
  assign qfix_w       = qe_q + 32'(ge_w);
  // quotient would not fit: the coordinate saturates either way
  assign big_w  = (prod_q[63:48] >= 16'(size_w));

  assign qe_w    = sat_q ? {1'b1, QW'(0)} : {1'b0, quo_q};
  assign sq_w    = neg_q ? -$signed({1'b0, qe_w}) : $signed({1'b0, qe_w});
  assign coord_w = axis_q ? (jet_pkg::Q_TWO - 40'(sq_w)) : (40'(sq_w) - jet_pkg::Q_TWO);

  assign full_o      = (state_q != S_IDLE);
  assign task_push_o = (state_q == S_PUSH) && !task_full_i;

  always_comb begin
    task_o.pixel_x = pix_q.pixel_x;
    task_o.pixel_y = pix_q.pixel_y;
    task_o.z_real  = zr_q;
    task_o.z_imag  = zi_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= 1'b0;
      pix_q   <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      prod_q  <= '0;
      sat_q   <= 1'b0;
      step_q  <= 1'b0;
      x_q     <= '0;
      qe_q    <= '0;
      r_q     <= '0;
      q1_q    <= '0;
      quo_q   <= '0;
      zr_q    <= '0;
      zi_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (push_i) begin
            pix_q   <= pix_i;
            axis_q  <= 1'b0;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          neg_q   <= p_w[33];
          mag_q   <= mag_w[31:0];
          state_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_q  <= {mult_w, 16'd0};
          state_q <= S_MUL_LO;
        end
        S_MUL_LO: begin
          prod_q  <= prod_q + 64'(mult_w);
          state_q <= S_DIV_INIT;
        end
        S_DIV_INIT: begin
          // high chunk of product / 2^14, below size * 2^14 when not saturating
          sat_q   <= big_w;
          x_q     <= 32'(prod_q[63:34]);
          step_q  <= 1'b0;
          state_q <= big_w ? S_FIN : S_RECIP;
        end
        S_RECIP: begin
          qe_q    <= recip_prod_w[63:32];
          state_q <= S_REM;
        end
        S_REM: begin
          r_q     <= x_q - bprod_w[31:0];
          state_q <= S_ADJ;
        end
        S_ADJ: begin
          if (!step_q) begin
            // remainder of the high chunk carries into the low 20 bits
            q1_q    <= qfix_w[13:0];
            x_q     <= {radj_w[11:0], prod_q[33:14]};
            step_q  <= 1'b1;
            state_q <= S_RECIP;
          end else begin
            quo_q   <= {q1_q, qfix_w[19:0]};
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (axis_q) begin
            zi_q    <= jet_pkg::sat32(coord_w);
            state_q <= S_PUSH;
          end else begin
            zr_q    <= jet_pkg::sat32(coord_w);
            axis_q  <= 1'b1;
            state_q <= S_PREP;
          end
        end
        S_PUSH: begin
          if (!task_full_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[design/jet_back.sv]
// back end: iterates z = z*z + c on one start point until escape or the iteration limit
module jet_back #(
  parameter int MAX_ITER = jet_pkg::MAX_ITER_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jet_pkg::task_t      task_i,
  input  logic                task_empty_i,
  output logic                task_pop_o,
  input  logic signed [30:0]  c_real_i,
  input  logic signed [30:0]  c_imag_i,
  output jet_pkg::res_t       res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);

  localparam int NB = $clog2(MAX_ITER + 2);
  localparam int NW = (NB > 9) ? NB : 9;
  localparam logic [NW-1:0] IterMax = NW'(MAX_ITER);

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_CHK, B_OUT} state_e;

  state_e             state_q;
  logic        [9:0]  px_q, py_q;
  logic signed [31:0] zr_q, zi_q;
  logic      [NW-1:0] n_q;
  logic signed [63:0] sr_q, si_q, pi_q;

  logic        [64:0] sum_w;
  logic               esc_w;
  logic signed [63:0] diff_w;
  logic signed [39:0] nr_w, ni_w;

  // escape when |z|^2 reaches 4.0 in q8.56
  assign sum_w  = {1'b0, sr_q} + {1'b0, si_q};
  assign esc_w  = (sum_w[64:58] != '0) || (n_q > IterMax);
  assign diff_w = sr_q - si_q;
  assign nr_w   = 40'($signed(diff_w[63:28])) + 40'(c_real_i);
  assign ni_w   = 40'($signed(pi_q[63:27])) + 40'(c_imag_i);

  assign task_pop_o = (state_q == B_IDLE) && !task_empty_i;
  assign res_push_o = (state_q == B_OUT) && !res_full_i;

  always_comb begin
    res_o.out_pixel_x = px_q;
    res_o.out_pixel_y = py_q;
    res_o.iter_count  = n_q[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      px_q    <= '0;
      py_q    <= '0;
      zr_q    <= '0;
      zi_q    <= '0;
      n_q     <= '0;
      sr_q    <= '0;
      si_q    <= '0;
      pi_q    <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (!task_empty_i) begin
            px_q    <= task_i.pixel_x;
            py_q    <= task_i.pixel_y;
            zr_q    <= task_i.z_real;
            zi_q    <= task_i.z_imag;
            n_q     <= '0;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          sr_q    <= zr_q * zr_q;
          si_q    <= zi_q * zi_q;
          pi_q    <= zr_q * zi_q;
          state_q <= B_CHK;
        end
        B_CHK: begin
          if (esc_w) begin
            state_q <= B_OUT;
          end else begin
            zr_q    <= jet_pkg::sat32(nr_w);
            zi_q    <= jet_pkg::sat32(ni_w);
            n_q     <= n_q + NW'(1);
            state_q <= B_MUL;
          end
        end
        B_OUT: begin
          if (!res_full_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

[design/julia_escape_time.sv]
// julia escape-time engine: pixel mapper, start point queue, iterator, result queue
// a start coordinate that saturates skips its divide in the mapper;
// the iterator takes one z step per pass through its multiply and check states;
// the mapper takes a new pixel only once idle, so it maps the next pixel while
// the iterator still works on the last one
// reset: registers return to their reset values, queues empty, ready right after reset
module julia_escape_time #(
  parameter int WIDTH_PIX  = jet_pkg::WIDTH_PIX_DEF,
  parameter int HEIGHT_PIX = jet_pkg::HEIGHT_PIX_DEF,
  parameter int MAX_ITER   = jet_pkg::MAX_ITER_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  jet_pkg::pix_t pix_i,
  output logic          empty,
  input  logic          pop,
  output jet_pkg::res_t res_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  typedef enum logic [2:0] {
    REG_C_REAL, REG_C_IMAG, REG_OFF_H, REG_OFF_V, REG_ZOOM
  } reg_idx_e;

  logic signed [30:0] c_real_q, c_imag_q;
  logic signed [31:0] off_h_q, off_v_q;
  logic        [31:0] zoom_q;
  logic               wr_en;

  jet_pkg::task_t task_in, task_out;
  logic           task_push, task_full, task_pop, task_empty;
  jet_pkg::res_t  res_in;
  logic           res_push, res_full;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_real_q <= jet_pkg::C_REAL_RST;
      c_imag_q <= jet_pkg::C_IMAG_RST;
      off_h_q  <= jet_pkg::OFF_RST;
      off_v_q  <= jet_pkg::OFF_RST;
      zoom_q   <= jet_pkg::ZOOM_RST;
    end else if (wr_en) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_C_REAL: c_real_q <= pwdata[30:0];
        REG_C_IMAG: c_imag_q <= pwdata[30:0];
        REG_OFF_H:  off_h_q  <= pwdata;
        REG_OFF_V:  off_v_q  <= pwdata;
        REG_ZOOM:   zoom_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_C_REAL: prdata = 32'(c_real_q);
      REG_C_IMAG: prdata = 32'(c_imag_q);
      REG_OFF_H:  prdata = off_h_q;
      REG_OFF_V:  prdata = off_v_q;
      REG_ZOOM:   prdata = zoom_q;
      default:    prdata = '0;
    endcase
  end

  jet_front #(
    .WIDTH_PIX  (WIDTH_PIX),
    .HEIGHT_PIX (HEIGHT_PIX)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .pix_i       (pix_i),
    .off_h_i     (off_h_q),
    .off_v_i     (off_v_q),
    .zoom_i      (zoom_q),
    .task_o      (task_in),
    .task_push_o (task_push),
    .task_full_i (task_full)
  );

  jet_fifo #(
    .WIDTH ($bits(jet_pkg::task_t)),
    .DEPTH (jet_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (task_push),
    .wdata_i (task_in),
    .full_o  (task_full),
    .pop_i   (task_pop),
    .rdata_o (task_out),
    .empty_o (task_empty)
  );

  jet_back #(
    .MAX_ITER (MAX_ITER)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (task_out),
    .task_empty_i (task_empty),
    .task_pop_o   (task_pop),
    .c_real_i     (c_real_q),
    .c_imag_i     (c_imag_q),
    .res_o        (res_in),
    .res_push_o   (res_push),
    .res_full_i   (res_full)
  );

  jet_fifo #(
    .WIDTH ($bits(jet_pkg::res_t)),
    .DEPTH (jet_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule
